// ----- design/mf3_pkg.sv -----
// shared types and constants for the 3x3 median filter
// transaction payload structs, size limits and register indexes; no dependencies

package mf3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 3;
    localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);

    localparam int PIX_W     = 8;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 12;
    localparam int CFG_W_W   = 12;
    localparam int CFG_H_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [8:0] win_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic             frame_last;
    } result_t;

endpackage

// ----- design/median_filter_3x3.sv -----
// 3x3 median filter top level: line memory, window and pipelined sorting network
// depends on mf3_pkg for payload structs, size limits and register indexes

// Takes one 8-bit grey pixel per clock in raster order and gives, for each interior
// pixel, the median of its 3x3 neighbourhood together with the centre row and column;
// border pixels give no transaction. Throughput is one pixel per clock unless a result
// is stalled, set by the single-read, single-write line memory holding the two rows
// above; an accepted pixel passes the line memory read register, then three register
// stages of three compare-exchange layers each. The whole pipeline holds while a
// result is stalled at the output register, so pixel_stall follows result_stall only
// when that register is full. Image size is to be written through the configuration
// port only while the block is idle, which the block does not enforce; values outside
// 3..2048 (width) and 3..4096 (height) are clamped. The line memory has no reset
// and no clearing pass: each frame must start with frame_start on its first pixel.

module median_filter_3x3
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  mf3_pkg::pixel_in_t                  pixel_data,

    output logic                                result_valid,
    input  logic                                result_stall,
    output mf3_pkg::result_t                    result_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mf3_pkg::CFG_DAT_W-1:0]       cfg_data
);

    // configuration
    logic [mf3_pkg::CFG_W_W-1:0] width_reg;
    logic [mf3_pkg::CFG_H_W-1:0] height_reg;
    logic [mf3_pkg::CFG_W_W-1:0] width_eff;
    logic [mf3_pkg::CFG_H_W-1:0] height_eff;

    // pipeline control
    logic advance;
    logic accept;

    // raster counters
    logic [mf3_pkg::COL_W-1:0] col_reg;
    logic [mf3_pkg::COL_W-1:0] col_next;
    logic [mf3_pkg::ROW_W-1:0] row_reg;
    logic [mf3_pkg::ROW_W-1:0] row_next;
    logic [mf3_pkg::COL_W-1:0] col_cur;
    logic [mf3_pkg::ROW_W-1:0] row_cur;
    logic                      col_wrap;
    logic                      row_wrap;

    // upper row in the high byte, lower row in the low byte
    logic [2*mf3_pkg::PIX_W-1:0] line_mem [mf3_pkg::MAX_WIDTH];
    logic [2*mf3_pkg::PIX_W-1:0] line_rd_reg;

    // stage 1: memory read in flight
    logic                      p1_valid_reg;
    mf3_pkg::pix_t             p1_pixel_reg;
    logic [mf3_pkg::COL_W-1:0] p1_col_reg;
    logic [mf3_pkg::ROW_W-1:0] p1_row_reg;
    logic                      p1_emit_reg;
    logic                      p1_last_reg;

    // window state
    mf3_pkg::win_t window_reg;
    mf3_pkg::win_t window_next;

    // stage 2: first three sort layers
    logic                      p2_valid_reg;
    mf3_pkg::win_t             p2_win_reg;
    mf3_pkg::win_t             p2_win_next;
    logic [mf3_pkg::COL_W-1:0] p2_col_reg;
    logic [mf3_pkg::ROW_W-1:0] p2_row_reg;
    logic                      p2_last_reg;

    // stage 3: middle three sort layers
    logic                      p3_valid_reg;
    mf3_pkg::win_t             p3_win_reg;
    mf3_pkg::win_t             p3_win_next;
    logic [mf3_pkg::COL_W-1:0] p3_col_reg;
    logic [mf3_pkg::ROW_W-1:0] p3_row_reg;
    logic                      p3_last_reg;

    // output register
    logic             result_valid_reg;
    mf3_pkg::result_t result_reg;
    mf3_pkg::win_t    out_win;

    function automatic mf3_pkg::win_t cx(mf3_pkg::win_t v, logic [3:0] a, logic [3:0] b);
        mf3_pkg::win_t r;
        r = v;
        if (v[a] > v[b])
        begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mf3_pkg::WIDTH_RESET;
            height_reg <= mf3_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mf3_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[mf3_pkg::CFG_W_W-1:0];
                mf3_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[mf3_pkg::CFG_H_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < mf3_pkg::CFG_W_W'(mf3_pkg::MIN_SIZE))
            width_eff = mf3_pkg::CFG_W_W'(mf3_pkg::MIN_SIZE);
        else if (width_reg > mf3_pkg::CFG_W_W'(mf3_pkg::MAX_WIDTH))
            width_eff = mf3_pkg::CFG_W_W'(mf3_pkg::MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg < mf3_pkg::CFG_H_W'(mf3_pkg::MIN_SIZE))
            height_eff = mf3_pkg::CFG_H_W'(mf3_pkg::MIN_SIZE);
        else if (height_reg > mf3_pkg::CFG_H_W'(mf3_pkg::MAX_HEIGHT))
            height_eff = mf3_pkg::CFG_H_W'(mf3_pkg::MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    // handshake
    assign advance     = !(result_valid_reg && result_stall);
    assign pixel_stall = !advance;
    assign accept      = pixel_valid && advance;

    // raster position
    always_comb
    begin
        col_cur  = pixel_data.frame_start ? '0 : col_reg;
        row_cur  = pixel_data.frame_start ? '0 : row_reg;
        col_wrap = ({1'b0, col_cur} + 1'b1) >= width_eff;
        row_wrap = ({1'b0, row_cur} + 1'b1) >= height_eff;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_cur + 1'b1;
            end
            else
            begin
                col_next = col_cur + 1'b1;
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory: read at accept, write back when the pixel leaves stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
            line_rd_reg <= line_mem[col_cur[mf3_pkg::LINE_ADDR_W-1:0]];
        if (advance && p1_valid_reg)
            line_mem[p1_col_reg[mf3_pkg::LINE_ADDR_W-1:0]]
                <= {line_rd_reg[mf3_pkg::PIX_W-1:0], p1_pixel_reg};
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (advance)
            p1_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_pixel_reg <= pixel_data.pixel;
            p1_col_reg   <= col_cur;
            p1_row_reg   <= row_cur;
            p1_emit_reg  <= (row_cur >= mf3_pkg::ROW_W'(2)) && (col_cur >= mf3_pkg::COL_W'(2));
            p1_last_reg  <= ({1'b0, row_cur} == height_eff - 1'b1)
                         && ({1'b0, col_cur} == width_eff - 1'b1);
        end
    end

    // window shift and first sort layers
    always_comb
    begin
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = line_rd_reg[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = line_rd_reg[mf3_pkg::PIX_W-1:0];
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = p1_pixel_reg;

        p2_win_next = window_next;
        p2_win_next = cx(p2_win_next, 4'd1, 4'd2);
        p2_win_next = cx(p2_win_next, 4'd4, 4'd5);
        p2_win_next = cx(p2_win_next, 4'd7, 4'd8);
        p2_win_next = cx(p2_win_next, 4'd0, 4'd1);
        p2_win_next = cx(p2_win_next, 4'd3, 4'd4);
        p2_win_next = cx(p2_win_next, 4'd6, 4'd7);
        p2_win_next = cx(p2_win_next, 4'd1, 4'd2);
        p2_win_next = cx(p2_win_next, 4'd4, 4'd5);
        p2_win_next = cx(p2_win_next, 4'd7, 4'd8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (advance && p1_valid_reg)
            window_reg <= window_next;
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (advance)
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p2_win_reg  <= p2_win_next;
            p2_col_reg  <= p1_col_reg - 1'b1;
            p2_row_reg  <= p1_row_reg - 1'b1;
            p2_last_reg <= p1_last_reg;
        end
    end

    // middle sort layers
    always_comb
    begin
        p3_win_next = p2_win_reg;
        p3_win_next = cx(p3_win_next, 4'd0, 4'd3);
        p3_win_next = cx(p3_win_next, 4'd5, 4'd8);
        p3_win_next = cx(p3_win_next, 4'd4, 4'd7);
        p3_win_next = cx(p3_win_next, 4'd3, 4'd6);
        p3_win_next = cx(p3_win_next, 4'd1, 4'd4);
        p3_win_next = cx(p3_win_next, 4'd2, 4'd5);
        p3_win_next = cx(p3_win_next, 4'd4, 4'd7);
    end

    // stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (advance)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p3_win_reg  <= p3_win_next;
            p3_col_reg  <= p2_col_reg;
            p3_row_reg  <= p2_row_reg;
            p3_last_reg <= p2_last_reg;
        end
    end

    // last sort layers
    always_comb
    begin
        out_win = p3_win_reg;
        out_win = cx(out_win, 4'd4, 4'd2);
        out_win = cx(out_win, 4'd6, 4'd4);
        out_win = cx(out_win, 4'd4, 4'd2);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= p3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.median     <= out_win[4];
            result_reg.centre_row <= p3_row_reg;
            result_reg.centre_col <= p3_col_reg;
            result_reg.frame_last <= p3_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // checks
    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> pixel_stall)
        else $error("pixel side not held while result is stalled");

    a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall && pixel_data.frame_start
        |=> p1_valid_reg && p1_col_reg == '0 && p1_row_reg == '0)
        else $error("frame start did not restart the raster position");

    a_result_follows_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg && advance |=> result_valid)
        else $error("result lost between last stage and output");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.centre_col != '0 && result_data.centre_row != '0)
        else $error("border pixel given as a result");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg && p1_emit_reg |-> p1_col_reg >= mf3_pkg::COL_W'(2))
        else $error("window emitted before two columns were filled");

endmodule

// ----- sim/median_filter_3x3_tb.sv -----
// testbench for median_filter_3x3: directed and random raster frames with random idling on both sides
// a small scoreboard class predicts every median transaction; depends on mf3_pkg and median_filter_3x3

`timescale 1ns / 1ps

module median_filter_3x3_tb;

    localparam int HALF_PERIOD     = 5;
    localparam int LIMIT_CYCLES    = 3_000_000;
    localparam int RANDOM_ITEMS    = 1150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;

    localparam logic [mf3_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [mf3_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    class median_scoreboard;
        logic [mf3_pkg::CFG_W_W-1:0] width_reg;
        logic [mf3_pkg::CFG_H_W-1:0] height_reg;
        mf3_pkg::pix_t               line_upper [mf3_pkg::MAX_WIDTH];
        mf3_pkg::pix_t               line_lower [mf3_pkg::MAX_WIDTH];
        mf3_pkg::pix_t               win [9];
        int unsigned                 col_count;
        int unsigned                 row_count;
        mf3_pkg::result_t            medians_due [$];
        int unsigned                 errors;

        function new();
            width_reg  = mf3_pkg::WIDTH_RESET;
            height_reg = mf3_pkg::HEIGHT_RESET;
            foreach (line_upper[i])
            begin
                line_upper[i] = '0;
                line_lower[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_count = 0;
            row_count = 0;
            errors    = 0;
        endfunction

        static function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v < mf3_pkg::MIN_SIZE)
                return mf3_pkg::MIN_SIZE;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void note_register(logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mf3_pkg::CFG_DAT_W-1:0] val);
            if (idx == mf3_pkg::CFG_IMAGE_WIDTH)
                width_reg = val[mf3_pkg::CFG_W_W-1:0];
            else if (idx == mf3_pkg::CFG_IMAGE_HEIGHT)
                height_reg = val[mf3_pkg::CFG_H_W-1:0];
        endfunction

        // value whose rank covers the fifth place of the nine
        function mf3_pkg::pix_t window_median();
            int            below;
            int            same;
            mf3_pkg::pix_t m;
            m = '0;
            for (int i = 0; i < 9; i++)
            begin
                below = 0;
                same  = 0;
                for (int j = 0; j < 9; j++)
                begin
                    if (win[j] < win[i])
                        below++;
                    else if (win[j] == win[i])
                        same++;
                end
                if (below <= 4 && below + same > 4)
                    m = win[i];
            end
            return m;
        endfunction

        function void note_pixel(mf3_pkg::pixel_in_t p);
            int unsigned      w;
            int unsigned      h;
            int unsigned      col;
            int unsigned      row;
            int unsigned      idx;
            mf3_pkg::pix_t    up;
            mf3_pkg::pix_t    lo;
            mf3_pkg::result_t r;
            w = clamp_size(width_reg, mf3_pkg::MAX_WIDTH);
            h = clamp_size(height_reg, mf3_pkg::MAX_HEIGHT);
            if (p.frame_start)
            begin
                col_count = 0;
                row_count = 0;
            end
            col = col_count;
            row = row_count;
            idx = col % mf3_pkg::MAX_WIDTH;
            up  = line_upper[idx];
            lo  = line_lower[idx];
            win[0] = win[1];
            win[1] = win[2];
            win[2] = up;
            win[3] = win[4];
            win[4] = win[5];
            win[5] = lo;
            win[6] = win[7];
            win[7] = win[8];
            win[8] = p.pixel;
            line_upper[idx] = lo;
            line_lower[idx] = p.pixel;
            if (row >= 2 && col >= 2)
            begin
                r.median     = window_median();
                r.centre_row = mf3_pkg::ROW_W'(row - 1);
                r.centre_col = mf3_pkg::COL_W'(col - 1);
                r.frame_last = (row == h - 1) && (col == w - 1);
                medians_due.push_back(r);
            end
            if (col + 1 >= w)
            begin
                col_count = 0;
                row_count = (row + 1 >= h) ? 0 : row + 1;
            end
            else
                col_count = col + 1;
        endfunction

        function void check_result(mf3_pkg::result_t got);
            mf3_pkg::result_t want;
            if (medians_due.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = medians_due.pop_front();
            if (got.median !== want.median)
            begin
                $display("%0t: median expected %0d actual %0d", $time, want.median, got.median);
                errors++;
            end
            if (got.centre_row !== want.centre_row)
            begin
                $display("%0t: centre_row expected %0d actual %0d", $time,
                         want.centre_row, got.centre_row);
                errors++;
            end
            if (got.centre_col !== want.centre_col)
            begin
                $display("%0t: centre_col expected %0d actual %0d", $time,
                         want.centre_col, got.centre_col);
                errors++;
            end
            if (got.frame_last !== want.frame_last)
            begin
                $display("%0t: frame_last expected %0b actual %0b", $time,
                         want.frame_last, got.frame_last);
                errors++;
            end
        endfunction

        function int pending();
            return medians_due.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          pixel_valid;
    logic                          pixel_stall;
    mf3_pkg::pixel_in_t            pixel_data;
    logic                          result_valid;
    logic                          result_stall;
    mf3_pkg::result_t              result_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mf3_pkg::CFG_DAT_W-1:0] cfg_data;

    median_scoreboard sb = new();
    int               src_gap_max;
    int               sink_gap_max;
    bit               hold_off_req;
    int unsigned      sent_count;

    median_filter_3x3 u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            sb.note_pixel(pixel_data);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
    end

    function automatic int draw_wait(int max_wait);
        if (max_wait == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, max_wait);
    endfunction

    function automatic int pick_gap_max();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 15;
        endcase
    endfunction

    task automatic send_pixel(mf3_pkg::pix_t px, logic mark);
        int gap;
        gap = draw_wait(src_gap_max);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data  <= '{pixel: px, frame_start: mark};
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // sender goes quiet until every outstanding median has arrived
    task automatic drain(int extra);
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic send_frame(int count, bit first_mark, int pause_at);
        int            mode;
        mf3_pkg::pix_t base;
        mf3_pkg::pix_t px;
        mode = $urandom_range(0, 3);
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                drain(SETTLE_CYCLES);
            case (mode)
                0:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                1:       px = base + 8'($urandom_range(0, 3));
                default: px = 8'($urandom_range(0, 255));
            endcase
            send_pixel(px, first_mark && (i == 0));
        end
    endtask

    task automatic write_reg(logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                             logic [mf3_pkg::CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_register(idx, val);
    endtask

    task automatic set_size(logic [mf3_pkg::CFG_DAT_W-1:0] w_val,
                            logic [mf3_pkg::CFG_DAT_W-1:0] h_val);
        drain(SETTLE_CYCLES);
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_SPARE_LO, 13'($urandom_range(0, 8191)));
        write_reg(mf3_pkg::CFG_IMAGE_WIDTH, w_val);
        write_reg(mf3_pkg::CFG_IMAGE_HEIGHT, h_val);
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_SPARE_HI, 13'($urandom_range(0, 8191)));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int k);
        logic [mf3_pkg::CFG_DAT_W-1:0] w_val;
        logic [mf3_pkg::CFG_DAT_W-1:0] h_val;
        int                            w_eff;
        int                            h_eff;
        int                            frames;
        int                            count;
        int                            pause_at;
        bit                            complete;
        case ($urandom_range(0, 9))
            0:       w_val = 13'($urandom_range(0, 2));
            1:       w_val = 13'($urandom_range(13, 40));
            2:       w_val = 13'h1000 | 13'($urandom_range(3, 9));
            default: w_val = 13'($urandom_range(3, 12));
        endcase
        case ($urandom_range(0, 7))
            0:       h_val = 13'($urandom_range(0, 2));
            1:       h_val = 13'($urandom_range(9, 16));
            default: h_val = 13'($urandom_range(3, 8));
        endcase
        if (k == 0 || k == 6)
        begin
            w_val = 13'($urandom_range(6, 12));
            h_val = 13'($urandom_range(6, 8));
        end
        set_size(w_val, h_val);
        w_eff = median_scoreboard::clamp_size(w_val[mf3_pkg::CFG_W_W-1:0], mf3_pkg::MAX_WIDTH);
        h_eff = median_scoreboard::clamp_size(h_val, mf3_pkg::MAX_HEIGHT);
        src_gap_max  = pick_gap_max();
        sink_gap_max = pick_gap_max();
        if (k == 0 || k == 6)
            hold_off_req = 1'b1;
        complete = 1'b0;
        frames   = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            count    = w_eff * h_eff;
            pause_at = (k == 3 && f == 0) ? count / 2 : -1;
            if (k != 3 && $urandom_range(0, 5) == 0)
                count = $urandom_range(1, count - 1);
            // after a whole frame the counters wrap by themselves
            send_frame(count, !(complete && $urandom_range(0, 2) == 0), pause_at);
            complete = (count == w_eff * h_eff);
        end
    endtask

    initial
    begin : result_sink
        int hold;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (result_valid && !result_stall)
            begin
                hold = draw_wait(sink_gap_max);
                if (hold > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        mf3_pkg::pix_t corner [18];
        int unsigned   base;
        int            k;
        pixel_valid  = 1'b0;
        pixel_data   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = mf3_pkg::CFG_IMAGE_WIDTH;
        cfg_data     = '0;
        rst_n        = 1'b0;
        src_gap_max  = 15;
        sink_gap_max = 15;
        hold_off_req = 1'b0;
        sent_count   = 0;
        corner = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                   8'hFF, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'hFF};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sizes below the minimum, then a second frame with no start mark
        set_size(13'd0, 13'd1);
        foreach (corner[i])
            send_pixel(corner[i], i == 0);
        // restart part way along a row
        send_pixel(8'h55, 1'b1);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h5A, 1'b1);

        base = sent_count;
        k    = 0;
        while (sent_count - base < RANDOM_ITEMS)
        begin
            random_phase(k);
            k++;
        end

        // largest sizes, with short gaps to keep the run brief
        src_gap_max  = 3;
        sink_gap_max = 3;
        set_size(13'd2048, 13'd3);
        send_frame(100, 1'b1, -1);
        set_size(13'd4095, 13'd3);
        send_frame(100, 1'b1, -1);
        set_size(13'd3, 13'd4096);
        send_frame(3 * 6, 1'b1, -1);
        set_size(13'd3, 13'd8191);
        send_frame(3 * 40, 1'b1, -1);

        drain(SETTLE_CYCLES);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
